// File: rtl/aprt_pkg.sv
// Shared constants and types of the acknowledgement-pending retransmit table.
`timescale 1ns / 1ps

package aprt_pkg;

    localparam int CAPACITY = 8;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int SEQ_W    = 16;
    localparam int DEST_W   = 8;
    localparam int TIME_W   = 32;
    localparam int RETRY_W  = 8;
    localparam int PEND_W   = 4;

    localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_ACK   = 3'd1,
        OP_FIND  = 3'd2,
        OP_RETRY = 3'd3,
        OP_DROP  = 3'd4
    } op_t;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [DEST_W-1:0]  dest;
        logic [TIME_W-1:0]  sent;
        logic [TIME_W-1:0]  tmo;
        logic [RETRY_W-1:0] retries;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } wr_req_t;

endpackage

// File: rtl/aprt_if.sv
// Valid/ready channel interfaces for request, response and configuration words.
`timescale 1ns / 1ps

interface aprt_req_if;
    logic                          valid;
    logic                          ready;
    logic [aprt_pkg::OP_W-1:0]     op;
    logic [aprt_pkg::SEQ_W-1:0]    seq_number;
    logic [aprt_pkg::DEST_W-1:0]   destination;
    logic [aprt_pkg::TIME_W-1:0]   now_time;
    logic [2:0]                    slot_index;
    logic [aprt_pkg::TIME_W-1:0]   retry_timeout;

    modport source (output valid, op, seq_number, destination, now_time, slot_index,
                    retry_timeout, input ready);
    modport sink   (input valid, op, seq_number, destination, now_time, slot_index,
                    retry_timeout, output ready);
endinterface

interface aprt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [2:0]                    slot_out;
    logic [aprt_pkg::SEQ_W-1:0]    seq_out;
    logic [aprt_pkg::DEST_W-1:0]   dest_node;
    logic [aprt_pkg::RETRY_W-1:0]  retries_out;
    logic [aprt_pkg::PEND_W-1:0]   pending_count;

    modport source (output valid, ok, slot_out, seq_out, dest_node, retries_out,
                    pending_count, input ready);
    modport sink   (input valid, ok, slot_out, seq_out, dest_node, retries_out,
                    pending_count, output ready);
endinterface

interface aprt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [aprt_pkg::TIME_W-1:0]   base_timeout;

    modport source (output valid, base_timeout, input ready);
    modport sink   (input valid, base_timeout, output ready);
endinterface

// File: rtl/aprt_entry_ram.sv
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module aprt_entry_ram
(
    input  logic                          clk,
    input  aprt_pkg::wr_req_t             wr,
    input  logic [aprt_pkg::SLOT_W-1:0]   rd_addr,
    output aprt_pkg::entry_t              rd_data
);

    aprt_pkg::entry_t mem [aprt_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/ack_pending_retransmit_table_unit.sv
// Top level of the acknowledgement-pending retransmit table.
// One request word is taken at a time, only in the idle state, which is entered on the edge
// that loads the previous result into the output register; that register may still wait for
// the sink. After the accepting edge, push, drop and unused ops go straight to the finish
// state, mark retry passes through the retry state (read, then write back through the entry
// memory), ack and find-expired through the scan state, which checks one slot per cycle in
// slot order from the single read port of the entry memory and stops at the first hit or
// after the last slot. The finish state loads the result once the output register is free.
// Valid bits live in flops and clear at reset; base_timeout resets to 1000 and may be
// written while the block is idle.
`timescale 1ns / 1ps

module ack_pending_retransmit_table_unit
(
    input  logic      clk,
    input  logic      rst_n,
    aprt_req_if.sink  req,
    aprt_rsp_if.source rsp,
    aprt_cfg_if.sink  cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RETRY,
        ST_FINISH
    } state_t;

    state_t                              state_reg, state_next;
    logic [aprt_pkg::CAPACITY-1:0]       valid_reg, valid_next;
    logic [aprt_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [aprt_pkg::SLOT_W-1:0]         victim_reg, victim_next;
    logic [aprt_pkg::SLOT_W-1:0]         idx_reg, idx_next;
    logic [aprt_pkg::TIME_W-1:0]         base_reg, base_next;

    logic [aprt_pkg::OP_W-1:0]           op_reg, op_next;
    logic [aprt_pkg::SEQ_W-1:0]          seq_reg, seq_next;
    logic [aprt_pkg::TIME_W-1:0]         now_reg, now_next;
    logic [aprt_pkg::TIME_W-1:0]         rto_reg, rto_next;
    logic [aprt_pkg::SLOT_W-1:0]         slot_reg, slot_next;

    logic                                res_ok_reg, res_ok_next;
    logic [aprt_pkg::SLOT_W-1:0]         res_slot_reg, res_slot_next;
    logic [aprt_pkg::SEQ_W-1:0]          res_seq_reg, res_seq_next;
    logic [aprt_pkg::DEST_W-1:0]         res_dest_reg, res_dest_next;
    logic [aprt_pkg::RETRY_W-1:0]        res_retries_reg, res_retries_next;

    logic                                out_valid_reg, out_valid_next;
    logic                                out_ok_reg, out_ok_next;
    logic [aprt_pkg::SLOT_W-1:0]         out_slot_reg, out_slot_next;
    logic [aprt_pkg::SEQ_W-1:0]          out_seq_reg, out_seq_next;
    logic [aprt_pkg::DEST_W-1:0]         out_dest_reg, out_dest_next;
    logic [aprt_pkg::RETRY_W-1:0]        out_retries_reg, out_retries_next;
    logic [aprt_pkg::COUNT_W-1:0]        out_count_reg, out_count_next;

    aprt_pkg::wr_req_t                   wr;
    logic [aprt_pkg::SLOT_W-1:0]         rd_addr;
    aprt_pkg::entry_t                    rd_data;

    logic                                free_found;
    logic [aprt_pkg::SLOT_W-1:0]         free_idx;
    logic [aprt_pkg::SLOT_W-1:0]         in_slot;
    logic [aprt_pkg::TIME_W-1:0]         thr;
    logic [aprt_pkg::TIME_W-1:0]         elapsed;
    logic                                hit_ack;
    logic                                hit_find;
    logic                                accept;

    aprt_entry_ram u_entry_ram
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept  = req.valid && req.ready;
    assign in_slot = aprt_pkg::SLOT_W'(req.slot_index);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = aprt_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = aprt_pkg::SLOT_W'(i);
            end
        end
    end

    assign thr      = (rd_data.tmo != '0) ? rd_data.tmo : base_reg;
    assign elapsed  = now_reg - rd_data.sent;
    assign hit_ack  = valid_reg[idx_reg] && (rd_data.seq == seq_reg);
    assign hit_find = valid_reg[idx_reg] && (elapsed >= thr);

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        victim_next      = victim_reg;
        idx_next         = idx_reg;
        base_next        = base_reg;
        op_next          = op_reg;
        seq_next         = seq_reg;
        now_next         = now_reg;
        rto_next         = rto_reg;
        slot_next        = slot_reg;
        res_ok_next      = res_ok_reg;
        res_slot_next    = res_slot_reg;
        res_seq_next     = res_seq_reg;
        res_dest_next    = res_dest_reg;
        res_retries_next = res_retries_reg;
        out_valid_next   = out_valid_reg;
        out_ok_next      = out_ok_reg;
        out_slot_next    = out_slot_reg;
        out_seq_next     = out_seq_reg;
        out_dest_next    = out_dest_reg;
        out_retries_next = out_retries_reg;
        out_count_next   = out_count_reg;
        wr               = '0;
        rd_addr          = idx_reg + aprt_pkg::SLOT_W'(1);

        if (cfg.valid)
        begin
            base_next = cfg.base_timeout;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (req.op == aprt_pkg::OP_RETRY) ? in_slot : '0;
                if (accept)
                begin
                    op_next          = req.op;
                    seq_next         = req.seq_number;
                    now_next         = req.now_time;
                    rto_next         = req.retry_timeout;
                    slot_next        = in_slot;
                    idx_next         = '0;
                    res_ok_next      = 1'b0;
                    res_slot_next    = '0;
                    res_seq_next     = '0;
                    res_dest_next    = '0;
                    res_retries_next = '0;
                    state_next       = ST_FINISH;
                    case (req.op)
                        aprt_pkg::OP_PUSH:
                        begin
                            wr.we           = 1'b1;
                            wr.data.seq     = req.seq_number;
                            wr.data.dest    = req.destination;
                            wr.data.sent    = req.now_time;
                            wr.data.tmo     = '0;
                            wr.data.retries = '0;
                            if (free_found)
                            begin
                                wr.addr              = free_idx;
                                valid_next[free_idx] = 1'b1;
                                count_next           = count_reg + aprt_pkg::COUNT_W'(1);
                                res_ok_next          = 1'b1;
                                res_slot_next        = free_idx;
                            end
                            else
                            begin
                                wr.addr       = victim_reg;
                                res_slot_next = victim_reg;
                                victim_next   = (victim_reg == aprt_pkg::SLOT_W'(aprt_pkg::CAPACITY - 1))
                                              ? '0 : victim_reg + aprt_pkg::SLOT_W'(1);
                            end
                        end
                        aprt_pkg::OP_ACK,
                        aprt_pkg::OP_FIND:
                        begin
                            state_next = ST_SCAN;
                        end
                        aprt_pkg::OP_RETRY:
                        begin
                            res_slot_next = in_slot;
                            state_next    = ST_RETRY;
                        end
                        aprt_pkg::OP_DROP:
                        begin
                            res_slot_next = in_slot;
                            if (valid_reg[in_slot])
                            begin
                                valid_next[in_slot] = 1'b0;
                                count_next          = count_reg - aprt_pkg::COUNT_W'(1);
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if ((op_reg == aprt_pkg::OP_ACK) && hit_ack)
                begin
                    valid_next[idx_reg] = 1'b0;
                    count_next          = count_reg - aprt_pkg::COUNT_W'(1);
                    res_ok_next         = 1'b1;
                    res_slot_next       = idx_reg;
                    res_dest_next       = rd_data.dest;
                    state_next          = ST_FINISH;
                end
                else if ((op_reg == aprt_pkg::OP_FIND) && hit_find)
                begin
                    res_ok_next      = 1'b1;
                    res_slot_next    = idx_reg;
                    res_seq_next     = rd_data.seq;
                    res_dest_next    = rd_data.dest;
                    res_retries_next = rd_data.retries;
                    state_next       = ST_FINISH;
                end
                else if (idx_reg == aprt_pkg::SLOT_W'(aprt_pkg::CAPACITY - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + aprt_pkg::SLOT_W'(1);
                end
            end

            ST_RETRY:
            begin
                if (valid_reg[slot_reg])
                begin
                    wr.we           = 1'b1;
                    wr.addr         = slot_reg;
                    wr.data         = rd_data;
                    wr.data.sent    = now_reg;
                    wr.data.tmo     = rto_reg;
                    if (rd_data.retries != aprt_pkg::RETRY_MAX)
                    begin
                        wr.data.retries = rd_data.retries + aprt_pkg::RETRY_W'(1);
                    end
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_ok_next      = res_ok_reg;
                    out_slot_next    = res_slot_reg;
                    out_seq_next     = res_seq_reg;
                    out_dest_next    = res_dest_reg;
                    out_retries_next = res_retries_reg;
                    out_count_next   = count_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            count_reg       <= '0;
            victim_reg      <= '0;
            idx_reg         <= '0;
            base_reg        <= aprt_pkg::TIME_W'(1000);
            op_reg          <= '0;
            seq_reg         <= '0;
            now_reg         <= '0;
            rto_reg         <= '0;
            slot_reg        <= '0;
            res_ok_reg      <= 1'b0;
            res_slot_reg    <= '0;
            res_seq_reg     <= '0;
            res_dest_reg    <= '0;
            res_retries_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_ok_reg      <= 1'b0;
            out_slot_reg    <= '0;
            out_seq_reg     <= '0;
            out_dest_reg    <= '0;
            out_retries_reg <= '0;
            out_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            count_reg       <= count_next;
            victim_reg      <= victim_next;
            idx_reg         <= idx_next;
            base_reg        <= base_next;
            op_reg          <= op_next;
            seq_reg         <= seq_next;
            now_reg         <= now_next;
            rto_reg         <= rto_next;
            slot_reg        <= slot_next;
            res_ok_reg      <= res_ok_next;
            res_slot_reg    <= res_slot_next;
            res_seq_reg     <= res_seq_next;
            res_dest_reg    <= res_dest_next;
            res_retries_reg <= res_retries_next;
            out_valid_reg   <= out_valid_next;
            out_ok_reg      <= out_ok_next;
            out_slot_reg    <= out_slot_next;
            out_seq_reg     <= out_seq_next;
            out_dest_reg    <= out_dest_next;
            out_retries_reg <= out_retries_next;
            out_count_reg   <= out_count_next;
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_valid_reg;
    assign rsp.ok            = out_ok_reg;
    assign rsp.slot_out      = 3'(out_slot_reg);
    assign rsp.seq_out       = out_seq_reg;
    assign rsp.dest_node     = out_dest_reg;
    assign rsp.retries_out   = out_retries_reg;
    assign rsp.pending_count = aprt_pkg::PEND_W'(out_count_reg);

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == aprt_pkg::COUNT_W'($countones(valid_reg)))
        else $error("pending count differs from number of valid slots");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= aprt_pkg::COUNT_W'(aprt_pkg::CAPACITY))
        else $error("pending count above capacity");

    a_write_only_idle_or_retry: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (state_reg == ST_IDLE || state_reg == ST_RETRY))
        else $error("entry memory written during scan or finish");

    a_retry_write_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.we && state_reg == ST_RETRY) |-> valid_reg[wr.addr])
        else $error("retry write to an empty slot");

endmodule
